### rtl/core/kettle_status_frame_parser_defines.svh
// Assertion macros for the kettle status frame parser checker.
// No dependencies.
`ifndef KETTLE_STATUS_FRAME_PARSER_DEFINES_SVH
`define KETTLE_STATUS_FRAME_PARSER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define KSFP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ksfp check failed");

// next-cycle implication, disabled during reset
`define KSFP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ksfp check failed");

`endif

### rtl/core/ksfp_pkg.sv
// Types and constants for the kettle status frame parser.
// No dependencies; used by the top level and its checker.
package ksfp_pkg;

   typedef enum logic [1:0] {
      OP_BYTE    = 2'd0,
      OP_TICK    = 2'd1,
      OP_NEXT_TX = 2'd2,
      OP_NONE    = 2'd3
   } ksfp_op_type;

   typedef enum logic [1:0] {
      CSR_OFFLINE_LIMIT = 2'd0,
      CSR_TEMP_LOW      = 2'd1,
      CSR_TEMP_HIGH     = 2'd2,
      CSR_UNUSED        = 2'd3
   } ksfp_csr_type;

   localparam logic [7:0] START_BYTE    = 8'hA5;
   localparam logic [7:0] TYPE_COMPACT  = 8'h22;
   localparam logic [7:0] TYPE_EXTENDED = 8'h12;
   localparam logic [7:0] TAG_COMPACT   = 8'h41;
   localparam logic [7:0] TAG_EXTENDED  = 8'h40;
   localparam logic [7:0] STATUS_MARK   = 8'h01;

   localparam logic [3:0] OFFLINE_LIMIT_RESET = 4'd10;
   localparam logic [7:0] TEMP_LOW_RESET      = 8'd40;
   localparam logic [7:0] TEMP_HIGH_RESET     = 8'd230;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] rx_byte;
   } ksfp_req_type;

   typedef struct packed {
      logic       frame_done;
      logic [7:0] done_kind;
      logic       status_taken;
      logic [7:0] water_temp;
      logic [7:0] kettle_setpoint;
      logic       heating;
      logic       on_base;
      logic       online;
      logic       registered;
      logic [7:0] tx_seq;
      logic [7:0] ctrl_seq;
   } ksfp_rsp_type;

endpackage

### rtl/core/kettle_status_frame_parser.sv
// Kettle status frame parser: byte-serial frame receiver and status tracker.
// Depends on ksfp_pkg.
//
// Usage:
//   req channel (req_valid/req_stall/req_data) carries one item per transfer:
//   a received link byte, a poll tick or a request for the next transmit
//   sequence. Every item gives exactly one result on the rsp channel
//   (rsp_valid/rsp_stall/rsp_data) with the frame completion flags and the
//   current kettle status.
//   csr channel (csr_valid/csr_ready/csr_index/csr_wdata) writes offline_limit,
//   temp_low and temp_high; csr_ready is always high. Write only while idle.
//   A result passes through the input register, then the result register,
//   before it is valid on rsp.
//   Throughput: one item per cycle while rsp_stall does not hold a result,
//   set by the combinational state update between the two registers.
//   Stall: while rsp_stall holds a waiting result, the input register still
//   takes one more item; req_stall rises only when both registers are full.
//   Reset (synchronous, active high): hunting for the start byte, all status
//   cleared, registers at defaults, both registers empty.
module kettle_status_frame_parser
   import ksfp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  ksfp_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output ksfp_rsp_type rsp_data,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [7:0]   csr_wdata
);

   typedef enum logic [1:0] {
      PH_HUNT,
      PH_HEADER,
      PH_PAYLOAD
   } phase_type;

   // captured payload slots
   localparam int CAP_MARK = 0;
   localparam int CAP_TAG  = 1;
   localparam int CAP_HEAT = 2;
   localparam int CAP_SETP = 3;
   localparam int CAP_TEMP = 4;
   localparam int CAP_CHEAT = 5;
   localparam int CAP_BASE = 6;

   // configuration
   logic [3:0] offline_limit_ff;
   logic [7:0] temp_low_ff, temp_high_ff;

   // pipeline registers
   logic         s1_valid_ff;
   ksfp_req_type s1_data_ff;
   logic         rsp_valid_ff;
   ksfp_rsp_type rsp_data_ff, rsp_in;

   // parser and status state
   phase_type   phase_ff, phase_in;
   logic [2:0]  hpos_ff, hpos_in;
   logic [7:0]  kind_ff, kind_in;
   logic [7:0]  seq_ff, seq_in;
   logic [15:0] len_ff, len_in;
   logic [15:0] cnt_ff, cnt_in;
   logic [7:0]  cap_ff [7];
   logic [7:0]  cap_in [7];
   logic [7:0]  temp_ff, temp_in;
   logic [7:0]  setp_ff, setp_in;
   logic        heat_ff, heat_in;
   logic        base_ff, base_in;
   logic        online_ff, online_in;
   logic        reg_ff, reg_in;
   logic [7:0]  last_rx_ff, last_rx_in;
   logic [7:0]  last_stat_ff, last_stat_in;
   logic [7:0]  tx_ff, tx_in;
   logic [3:0]  silence_ff, silence_in;

   logic out_free, advance, csr_write;
   logic finish, taken, in_range;
   logic [7:0] byte_v;
   logic [3:0] sil_v;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      phase_in     = phase_ff;
      hpos_in      = hpos_ff;
      kind_in      = kind_ff;
      seq_in       = seq_ff;
      len_in       = len_ff;
      cnt_in       = cnt_ff;
      cap_in       = cap_ff;
      temp_in      = temp_ff;
      setp_in      = setp_ff;
      heat_in      = heat_ff;
      base_in      = base_ff;
      online_in    = online_ff;
      reg_in       = reg_ff;
      last_rx_in   = last_rx_ff;
      last_stat_in = last_stat_ff;
      tx_in        = tx_ff;
      silence_in   = silence_ff;
      finish       = 1'b0;
      taken        = 1'b0;
      sil_v        = silence_ff;
      byte_v       = s1_data_ff.rx_byte;

      case (ksfp_op_type'(s1_data_ff.opcode))
         OP_BYTE: begin
            case (phase_ff)
               PH_HUNT: begin
                  if (byte_v == START_BYTE) begin
                     phase_in = PH_HEADER;
                     hpos_in  = 3'd0;
                  end
               end
               PH_HEADER: begin
                  case (hpos_ff)
                     3'd0: kind_in = byte_v;
                     3'd1: seq_in  = byte_v;
                     3'd2: len_in  = {8'd0, byte_v};
                     3'd3: len_in  = {byte_v, len_ff[7:0]};
                     default: ;
                  endcase
                  // fifth header byte is the checksum, not checked
                  if (hpos_ff >= 3'd4) begin
                     hpos_in = 3'd0;
                     cnt_in  = 16'd0;
                     for (int i = 0; i < 7; i++) cap_in[i] = 8'd0;
                     if (len_ff == 16'd0) finish = 1'b1;
                     else phase_in = PH_PAYLOAD;
                  end else begin
                     hpos_in = hpos_ff + 3'd1;
                  end
               end
               PH_PAYLOAD: begin
                  case (cnt_ff)
                     16'd0:  cap_in[CAP_MARK]  = byte_v;
                     16'd1:  cap_in[CAP_TAG]   = byte_v;
                     16'd4:  cap_in[CAP_HEAT]  = byte_v;
                     16'd6:  cap_in[CAP_SETP]  = byte_v;
                     16'd7:  cap_in[CAP_TEMP]  = byte_v;
                     16'd8:  cap_in[CAP_CHEAT] = byte_v;
                     16'd14: cap_in[CAP_BASE]  = byte_v;
                     default: ;
                  endcase
                  cnt_in = cnt_ff + 16'd1;
                  if (cnt_in >= len_ff) finish = 1'b1;
               end
               default: phase_in = PH_HUNT;
            endcase
         end
         OP_TICK: begin
            if (silence_ff < offline_limit_ff) sil_v = silence_ff + 4'd1;
            silence_in = sil_v;
            if (sil_v >= offline_limit_ff) online_in = 1'b0;
         end
         OP_NEXT_TX: begin
            if (tx_ff == 8'd0 && last_rx_ff != 8'd0) tx_in = last_rx_ff + 8'd1;
            else tx_in = tx_ff + 8'd1;
         end
         default: ;
      endcase

      in_range = (cap_in[CAP_TEMP] >= temp_low_ff) && (cap_in[CAP_TEMP] <= temp_high_ff);

      if (finish) begin
         phase_in   = PH_HUNT;
         last_rx_in = seq_ff;
         if (kind_ff == TYPE_EXTENDED) reg_in = 1'b1;
         if (kind_ff == TYPE_COMPACT) begin
            if (len_ff >= 16'd9 && cap_in[CAP_MARK] == STATUS_MARK &&
                cap_in[CAP_TAG] == TAG_COMPACT && in_range) begin
               heat_in = (cap_in[CAP_CHEAT] != 8'd0);
               taken   = 1'b1;
            end
         end else if (kind_ff == TYPE_EXTENDED) begin
            if (len_ff >= 16'd8 && cap_in[CAP_MARK] == STATUS_MARK &&
                cap_in[CAP_TAG] == TAG_EXTENDED && in_range) begin
               heat_in = (cap_in[CAP_HEAT] != 8'd0);
               if (len_ff >= 16'd15) base_in = (cap_in[CAP_BASE] == 8'd0);
               taken = 1'b1;
            end
         end
         if (taken) begin
            temp_in      = cap_in[CAP_TEMP];
            setp_in      = cap_in[CAP_SETP];
            online_in    = 1'b1;
            last_stat_in = seq_ff;
            silence_in   = 4'd0;
         end
      end

      rsp_in.frame_done      = finish;
      rsp_in.done_kind       = finish ? kind_ff : 8'd0;
      rsp_in.status_taken    = taken;
      rsp_in.water_temp      = temp_in;
      rsp_in.kettle_setpoint = setp_in;
      rsp_in.heating         = heat_in;
      rsp_in.on_base         = base_in;
      rsp_in.online          = online_in;
      rsp_in.registered      = reg_in;
      rsp_in.tx_seq          = tx_in;
      rsp_in.ctrl_seq        = (last_stat_in != 8'd0) ? last_stat_in : last_rx_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offline_limit_ff <= OFFLINE_LIMIT_RESET;
         temp_low_ff      <= TEMP_LOW_RESET;
         temp_high_ff     <= TEMP_HIGH_RESET;
         s1_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         phase_ff         <= PH_HUNT;
         hpos_ff          <= 3'd0;
         kind_ff          <= 8'd0;
         seq_ff           <= 8'd0;
         len_ff           <= 16'd0;
         cnt_ff           <= 16'd0;
         for (int i = 0; i < 7; i++) cap_ff[i] <= 8'd0;
         temp_ff          <= 8'd0;
         setp_ff          <= 8'd0;
         heat_ff          <= 1'b0;
         base_ff          <= 1'b0;
         online_ff        <= 1'b0;
         reg_ff           <= 1'b0;
         last_rx_ff       <= 8'd0;
         last_stat_ff     <= 8'd0;
         tx_ff            <= 8'd0;
         silence_ff       <= 4'd0;
      end else begin
         if (csr_write) begin
            case (ksfp_csr_type'(csr_index))
               CSR_OFFLINE_LIMIT: offline_limit_ff <= csr_wdata[3:0];
               CSR_TEMP_LOW:      temp_low_ff      <= csr_wdata;
               CSR_TEMP_HIGH:     temp_high_ff     <= csr_wdata;
               default: ;
            endcase
         end
         if (!req_stall) begin
            s1_valid_ff <= req_valid;
            s1_data_ff  <= req_data;
         end
         if (out_free) begin
            rsp_valid_ff <= s1_valid_ff;
            rsp_data_ff  <= rsp_in;
         end
         if (advance) begin
            phase_ff     <= phase_in;
            hpos_ff      <= hpos_in;
            kind_ff      <= kind_in;
            seq_ff       <= seq_in;
            len_ff       <= len_in;
            cnt_ff       <= cnt_in;
            cap_ff       <= cap_in;
            temp_ff      <= temp_in;
            setp_ff      <= setp_in;
            heat_ff      <= heat_in;
            base_ff      <= base_in;
            online_ff    <= online_in;
            reg_ff       <= reg_in;
            last_rx_ff   <= last_rx_in;
            last_stat_ff <= last_stat_in;
            tx_ff        <= tx_in;
            silence_ff   <= silence_in;
         end
      end
   end

endmodule

### rtl/core/ksfp_checker.sv
// Port-level checks for the kettle status frame parser, bound to the top level.
// Depends on ksfp_pkg and kettle_status_frame_parser_defines.svh.
`include "kettle_status_frame_parser_defines.svh"

module ksfp_checker
   import ksfp_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input ksfp_rsp_type rsp_data
);

   logic held, idle_kind, taken, status_kind, taken_ok, ext_done;

   assign held        = rsp_valid && rsp_stall;
   assign idle_kind   = rsp_valid && !rsp_data.frame_done;
   assign taken       = rsp_valid && rsp_data.status_taken;
   assign status_kind = (rsp_data.done_kind == TYPE_COMPACT) ||
                        (rsp_data.done_kind == TYPE_EXTENDED);
   assign taken_ok    = rsp_data.frame_done && rsp_data.online && status_kind;
   assign ext_done    = rsp_valid && rsp_data.frame_done &&
                        (rsp_data.done_kind == TYPE_EXTENDED);

   // a held result keeps its value
   `KSFP_ASSERT_NEXT(a_rsp_hold, clock, reset, held, rsp_valid && $stable(rsp_data))

   // no frame type is reported without a completed frame
   `KSFP_ASSERT_NOW(a_type_zero, clock, reset, idle_kind, rsp_data.done_kind == 8'd0)

   // an accepted status completes a status-type frame and brings the kettle online
   `KSFP_ASSERT_NOW(a_taken_ok, clock, reset, taken, taken_ok)

   // any completed extended frame leaves the block registered
   `KSFP_ASSERT_NOW(a_registered, clock, reset, ext_done, rsp_data.registered)

endmodule

bind kettle_status_frame_parser ksfp_checker u_ksfp_checker (.*);

### bench/kettle_status_frame_parser_test.sv
// Self-checking bench for kettle_status_frame_parser: random framed byte traffic, ticks and
// sequence requests under several register settings, checked against a built-in predictor.
// Depends on ksfp_pkg and the kettle_status_frame_parser RTL.
module kettle_status_frame_parser_test
   import ksfp_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int HOLD_CYCLES    = 64;

   typedef enum logic [1:0] {SEEK_START, IN_HEADER, IN_PAYLOAD} parse_phase_type;
   typedef enum {BODY_RANDOM, BODY_STATUS, BODY_SPOILED} body_kind_type;

   logic         clock;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   ksfp_req_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   ksfp_rsp_type rsp_data;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [1:0]   csr_index = CSR_OFFLINE_LIMIT;
   logic [7:0]   csr_wdata = '0;

   kettle_status_frame_parser i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // traffic and bookkeeping
   ksfp_req_type link_items_q[$];
   ksfp_rsp_type expected_status_q[$];
   int unsigned  items_queued = 0;
   int unsigned  results_checked = 0;
   int unsigned  frames_seen = 0;
   int unsigned  status_seen = 0;
   int unsigned  csr_writes = 0;
   int unsigned  holds_done = 0;
   int unsigned  fail_count = 0;
   int unsigned  idle_cycles = 0;
   int unsigned  sender_idle_pct = 0;
   int unsigned  stall_pct = 0;
   logic         hold_armed = 1'b0;
   int unsigned  hold_left = 0;

   // predictor state and its copy of the registers
   parse_phase_type parse_at;
   logic [2:0]   hdr_idx;
   logic [7:0]   kind_r, seq_r;
   logic [15:0]  len_r, body_cnt;
   logic [7:0]   grab [7];
   logic [7:0]   temp_r, setpoint_r;
   logic         heat_r, base_r, online_r, reg_r;
   logic [7:0]   last_rx_r, last_status_r, tx_r;
   logic [3:0]   quiet_ticks;
   logic [3:0]   lim_offline;
   logic [7:0]   temp_floor, temp_ceiling;

   function automatic void reset_status_model();
      parse_at = SEEK_START;
      hdr_idx = '0;
      kind_r = '0;
      seq_r = '0;
      len_r = '0;
      body_cnt = '0;
      foreach (grab[i]) grab[i] = '0;
      temp_r = '0;
      setpoint_r = '0;
      heat_r = 1'b0;
      base_r = 1'b0;
      online_r = 1'b0;
      reg_r = 1'b0;
      last_rx_r = '0;
      last_status_r = '0;
      tx_r = '0;
      quiet_ticks = '0;
      lim_offline = OFFLINE_LIMIT_RESET;
      temp_floor = TEMP_LOW_RESET;
      temp_ceiling = TEMP_HIGH_RESET;
   endfunction

   // judge a completed frame; grab[] holds payload offsets 0,1,4,6,7,8,14
   function automatic logic judge_frame();
      logic ok;
      logic in_range;
      ok = 1'b0;
      in_range = (grab[4] >= temp_floor) && (grab[4] <= temp_ceiling);
      last_rx_r = seq_r;
      if (kind_r == TYPE_EXTENDED) reg_r = 1'b1;
      if (kind_r == TYPE_COMPACT) begin
         if (len_r >= 16'd9 && grab[0] == STATUS_MARK && grab[1] == TAG_COMPACT &&
             in_range) begin
            heat_r = (grab[5] != 0);
            ok = 1'b1;
         end
      end else if (kind_r == TYPE_EXTENDED) begin
         if (len_r >= 16'd8 && grab[0] == STATUS_MARK && grab[1] == TAG_EXTENDED &&
             in_range) begin
            heat_r = (grab[2] != 0);
            if (len_r >= 16'd15) base_r = (grab[6] == 0);
            ok = 1'b1;
         end
      end
      if (ok) begin
         temp_r = grab[4];
         setpoint_r = grab[3];
         online_r = 1'b1;
         last_status_r = last_rx_r;
         quiet_ticks = '0;
      end
      parse_at = SEEK_START;
      return ok;
   endfunction

   function automatic ksfp_rsp_type predict_status(input ksfp_req_type item);
      ksfp_rsp_type r;
      logic [7:0]   b;
      logic         done;
      logic         taken;
      b = item.rx_byte;
      done = 1'b0;
      taken = 1'b0;
      case (item.opcode)
         OP_BYTE: begin
            case (parse_at)
               SEEK_START: begin
                  if (b == START_BYTE) begin
                     parse_at = IN_HEADER;
                     hdr_idx = '0;
                  end
               end
               IN_HEADER: begin
                  case (hdr_idx)
                     3'd0: kind_r = b;
                     3'd1: seq_r = b;
                     3'd2: len_r = {8'h00, b};
                     3'd3: len_r[15:8] = b;
                     default: ;
                  endcase
                  if (hdr_idx >= 3'd4) begin
                     // checksum byte: ignored, header complete
                     hdr_idx = '0;
                     body_cnt = '0;
                     foreach (grab[i]) grab[i] = '0;
                     if (len_r == 0) begin
                        done = 1'b1;
                        taken = judge_frame();
                     end else begin
                        parse_at = IN_PAYLOAD;
                     end
                  end else begin
                     hdr_idx = hdr_idx + 3'd1;
                  end
               end
               default: begin
                  case (body_cnt)
                     16'd0:  grab[0] = b;
                     16'd1:  grab[1] = b;
                     16'd4:  grab[2] = b;
                     16'd6:  grab[3] = b;
                     16'd7:  grab[4] = b;
                     16'd8:  grab[5] = b;
                     16'd14: grab[6] = b;
                     default: ;
                  endcase
                  body_cnt = body_cnt + 16'd1;
                  if (body_cnt >= len_r) begin
                     done = 1'b1;
                     taken = judge_frame();
                  end
               end
            endcase
         end
         OP_TICK: begin
            if (quiet_ticks < lim_offline) quiet_ticks = quiet_ticks + 4'd1;
            if (quiet_ticks >= lim_offline) online_r = 1'b0;
         end
         OP_NEXT_TX: begin
            if (tx_r == 0 && last_rx_r != 0) tx_r = last_rx_r + 8'd1;
            else tx_r = tx_r + 8'd1;
         end
         default: ;
      endcase
      r.frame_done = done;
      r.done_kind = done ? kind_r : 8'h00;
      r.status_taken = taken;
      r.water_temp = temp_r;
      r.kettle_setpoint = setpoint_r;
      r.heating = heat_r;
      r.on_base = base_r;
      r.online = online_r;
      r.registered = reg_r;
      r.tx_seq = tx_r;
      r.ctrl_seq = (last_status_r != 0) ? last_status_r : last_rx_r;
      return r;
   endfunction

   // driver: a stalled transfer holds its payload
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_status_q.insert(expected_status_q.size(), predict_status(req_data));
         end
         if (!req_valid || !req_stall) begin
            if (link_items_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               req_valid <= 1'b1;
               req_data <= link_items_q.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver stall: random, or one long hold when armed
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else if (hold_armed && holds_done == 0) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES - 1;
         holds_done <= holds_done + 1;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   task automatic check_field(input string field, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : result_monitor
      ksfp_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_status_q.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual %h", $time, rsp_data);
            fail_count++;
         end else begin
            want = expected_status_q.pop_front();
            check_field("frame_done", want.frame_done, rsp_data.frame_done);
            check_field("done_kind", want.done_kind, rsp_data.done_kind);
            check_field("status_taken", want.status_taken, rsp_data.status_taken);
            check_field("water_temp", want.water_temp, rsp_data.water_temp);
            check_field("kettle_setpoint", want.kettle_setpoint, rsp_data.kettle_setpoint);
            check_field("heating", want.heating, rsp_data.heating);
            check_field("on_base", want.on_base, rsp_data.on_base);
            check_field("online", want.online, rsp_data.online);
            check_field("registered", want.registered, rsp_data.registered);
            check_field("tx_seq", want.tx_seq, rsp_data.tx_seq);
            check_field("ctrl_seq", want.ctrl_seq, rsp_data.ctrl_seq);
            if (want.frame_done) frames_seen++;
            if (want.status_taken) status_seen++;
            results_checked++;
         end
      end
   end

   // watchdog: cycles with no transfer on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired, %0d results outstanding", $time,
                  items_queued - results_checked);
         $display("FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic queue_byte(input logic [7:0] b);
      ksfp_req_type it;
      it.opcode = OP_BYTE;
      it.rx_byte = b;
      link_items_q.insert(link_items_q.size(), it);
      items_queued++;
   endtask

   task automatic queue_op(input ksfp_op_type op);
      ksfp_req_type it;
      it.opcode = op;
      it.rx_byte = 8'($urandom);
      link_items_q.insert(link_items_q.size(), it);
      items_queued++;
   endtask

   // random byte, now and then the start byte as plain data
   function automatic logic [7:0] any_byte();
      return ($urandom_range(7) == 0) ? START_BYTE : 8'($urandom);
   endfunction

   task automatic queue_frame(input logic [7:0] kind, input logic [7:0] seq,
                              input logic [15:0] len, input body_kind_type shape,
                              input logic [7:0] temp, input bit mix);
      logic [7:0] b;
      int         spoil_at;
      spoil_at = $urandom_range(1);
      queue_byte(START_BYTE);
      queue_byte(kind);
      queue_byte(seq);
      queue_byte(len[7:0]);
      queue_byte(len[15:8]);
      queue_byte(8'($urandom));
      for (int i = 0; i < len; i++) begin
         b = any_byte();
         if (shape != BODY_RANDOM) begin
            case (i)
               0:         b = STATUS_MARK;
               1:         b = (kind == TYPE_COMPACT) ? TAG_COMPACT : TAG_EXTENDED;
               4, 8, 14:  b = $urandom_range(1) ? 8'h00 : 8'($urandom);
               7:         b = temp;
               default: ;
            endcase
            if (shape == BODY_SPOILED && i == spoil_at) b = b ^ 8'($urandom_range(1, 255));
         end
         // ticks and requests may arrive between link bytes
         if (mix && $urandom_range(15) == 0) queue_op(ksfp_op_type'($urandom_range(1, 3)));
         queue_byte(b);
      end
   endtask

   function automatic logic [7:0] pick_seq();
      case ($urandom_range(7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_len(input logic [7:0] kind);
      int unsigned least;
      least = (kind == TYPE_COMPACT) ? 9 : 8;
      if ($urandom_range(9) < 8) return 16'($urandom_range(least, least + 8));
      return 16'($urandom_range(least - 1));
   endfunction

   function automatic logic [7:0] pick_temp();
      case ($urandom_range(9))
         0: return temp_floor;
         1: return temp_ceiling;
         2, 3: return 8'($urandom);
         default: begin
            if (temp_floor <= temp_ceiling) return 8'($urandom_range(temp_floor, temp_ceiling));
            return 8'($urandom);
         end
      endcase
   endfunction

   task automatic queue_random(input int unsigned count);
      int unsigned stop;
      int unsigned pick;
      logic [7:0]  kind;
      stop = items_queued + count;
      while (items_queued < stop) begin
         pick = $urandom_range(99);
         kind = $urandom_range(1) ? TYPE_COMPACT : TYPE_EXTENDED;
         if (pick < 55) begin
            queue_frame(kind, pick_seq(), pick_len(kind), BODY_STATUS, pick_temp(), 1'b1);
         end else if (pick < 65) begin
            queue_frame(kind, pick_seq(), pick_len(kind), BODY_SPOILED, pick_temp(), 1'b1);
         end else if (pick < 73) begin
            queue_frame(8'($urandom), pick_seq(), 16'($urandom_range(6)), BODY_RANDOM,
                        8'h00, 1'b1);
         end else if (pick < 86) begin
            repeat ($urandom_range(1, 12)) queue_op(OP_TICK);
         end else if (pick < 92) begin
            repeat ($urandom_range(1, 3)) queue_op(OP_NEXT_TX);
         end else if (pick < 95) begin
            queue_op(OP_NONE);
         end else begin
            // line noise while hunting
            repeat ($urandom_range(1, 4)) queue_byte(8'($urandom));
         end
      end
   endtask

   // every item yields one result, so idle means all queued items answered
   task automatic wait_idle();
      while (results_checked != items_queued) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input ksfp_csr_type idx, input logic [7:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      csr_writes++;
      case (idx)
         CSR_OFFLINE_LIMIT: lim_offline = val[3:0];
         CSR_TEMP_LOW:      temp_floor = val;
         CSR_TEMP_HIGH:     temp_ceiling = val;
         default: ;
      endcase
   endtask

   task automatic set_pace(input int unsigned sender_pct, input int unsigned receiver_pct);
      sender_idle_pct = sender_pct;
      stall_pct = receiver_pct;
   endtask

   initial begin
      reset_status_model();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // defaults; directed items first
      set_pace(24, 49);
      queue_op(OP_TICK);
      queue_op(OP_NEXT_TX);
      queue_op(OP_NONE);
      queue_byte(8'hFF);
      queue_frame(TYPE_EXTENDED, 8'h00, 16'd0, BODY_STATUS, 8'h00, 1'b0);
      queue_frame(TYPE_COMPACT, START_BYTE, 16'd9, BODY_STATUS, TEMP_HIGH_RESET, 1'b0);
      queue_random(60);
      wait_idle();

      // widest settings
      csr_write(CSR_OFFLINE_LIMIT, 8'd15);
      csr_write(CSR_TEMP_LOW, 8'd0);
      csr_write(CSR_TEMP_HIGH, 8'd255);
      queue_random(50);
      wait_idle();

      set_pace(49, 24);
      csr_write(CSR_OFFLINE_LIMIT, 8'd1);
      csr_write(CSR_TEMP_LOW, 8'd100);
      csr_write(CSR_TEMP_HIGH, 8'd100);
      queue_random(45);
      wait_idle();

      // zero limit and an inverted range: nothing accepted, every tick drops online
      csr_write(CSR_OFFLINE_LIMIT, 8'd0);
      csr_write(CSR_TEMP_LOW, 8'd200);
      csr_write(CSR_TEMP_HIGH, 8'd50);
      csr_write(CSR_UNUSED, 8'($urandom));
      queue_random(35);
      wait_idle();

      set_pace(0, 0);
      csr_write(CSR_OFFLINE_LIMIT, 8'd3);
      csr_write(CSR_TEMP_LOW, 8'd60);
      csr_write(CSR_TEMP_HIGH, 8'd212);
      queue_random(10);
      @(posedge clock);
      hold_armed <= 1'b1;
      // length high byte in use, on-base offset reached
      queue_frame(TYPE_EXTENDED, 8'h5A, 16'h0100, BODY_STATUS, pick_temp(), 1'b0);
      queue_random(15);
      wait_idle();

      $display("Ran %0d items over %0d register writes and %0d long receiver hold(s);",
               items_queued, csr_writes, holds_done);
      $display("%0d frames completed, %0d status reports accepted.", frames_seen, status_seen);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
